// ===== src/spi_squib_and_event_register_slave_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the SPI squib / event recorder slave.
// Each form checks on the rising edge of clock and is disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SPI_SQUIB_AND_EVENT_REGISTER_SLAVE_MACROS_SVH
`define SPI_SQUIB_AND_EVENT_REGISTER_SLAVE_MACROS_SVH

// same-cycle implication
`define SSR_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define SSR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/ssr_pkg.sv =====
// ----------------------------------------------------------------------------
// ssr_pkg
// Types, register map and constants of the SPI squib / event recorder slave.
// ----------------------------------------------------------------------------
`default_nettype none

package ssr_pkg;

   localparam int REG_COUNT_DEFAULT = 128;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // request event codes
   typedef enum logic [1:0] {FN_BEGIN, FN_BYTE, FN_END, FN_SPARE} func_code_type;

   // both chip selects latched at begin
   localparam logic [1:0] SEL_BOTH = 2'b11;

   // recorder register map
   localparam logic [6:0] A_ID        = 7'h0F;
   localparam logic [6:0] A_STATUS    = 7'h10;
   localparam logic [6:0] A_LOG_FIRST = 7'h11;
   localparam logic [6:0] A_LAST_CMD  = 7'h14;
   localparam logic [6:0] A_SQUIB_OUT = 7'h15;
   localparam logic [6:0] A_LOG_LAST  = 7'h19;
   localparam logic [6:0] A_COUNT_H   = 7'h1A;
   localparam logic [6:0] A_COUNT_L   = 7'h1B;
   localparam logic [6:0] A_CTRL      = 7'h20;
   localparam logic [6:0] A_FAULT     = 7'h21;

   localparam int LOG_N     = 9;
   localparam int LOG_IDX_W = $clog2(LOG_N);
   localparam logic [LOG_IDX_W-1:0] LOG_LAST_CMD  = LOG_IDX_W'(A_LAST_CMD - A_LOG_FIRST);
   localparam logic [LOG_IDX_W-1:0] LOG_SQUIB_OUT = LOG_IDX_W'(A_SQUIB_OUT - A_LOG_FIRST);

   // status bits
   localparam logic [5:0] ST_INIT  = 6'h01;
   localparam logic [5:0] ST_READ  = 6'h02;
   localparam logic [5:0] ST_WRITE = 6'h04;
   localparam logic [5:0] ST_SQUIB = 6'h08;
   localparam logic [5:0] ST_LOG   = 6'h10;
   localparam logic [5:0] ST_FAULT = 6'h20;

   // control register bits
   localparam int CTRL_RESET_STATUS = 0;
   localparam int CTRL_CLEAR_LOG    = 1;

   localparam logic [7:0] ID_VALUE       = 8'hE4;
   localparam logic [7:0] TX_IDLE        = 8'hEE;
   localparam logic [7:0] FAULT_BOTH_SEL = 8'hE1;
   localparam logic [7:0] FAULT_BAD_CMD  = 8'hE2;

   localparam logic [7:0] CMD_SAFE      = 8'h00;
   localparam logic [7:0] CMD_FIRE_ODD  = 8'hA5;
   localparam logic [7:0] CMD_FIRE_EVEN = 8'h5A;
   localparam logic [4:0] MASK_FIRE_ODD  = 5'h15;
   localparam logic [4:0] MASK_FIRE_EVEN = 5'h0A;

   typedef enum logic [1:0] {OP_NOP, OP_BEGIN, OP_END, OP_BYTE} op_kind_type;
   typedef enum logic [1:0] {FA_NONE, FA_CLEAR, FA_SET_BOTH} fault_act_type;

   // one classified beat handed from front to back
   typedef struct packed {
      op_kind_type   kind;
      fault_act_type fault_act;
      logic          read_seen;
      logic          rd;
      logic          wr;
      logic          idle_tx;
      logic          squib;
      logic [6:0]    addr;
      logic [7:0]    data;
   } op_type;

   // registers kept in flops rather than in the memory
   function automatic logic is_special(input logic [6:0] a);
      return (a >= A_ID && a <= A_COUNT_L) || a == A_CTRL || a == A_FAULT;
   endfunction

endpackage

`default_nettype wire

// ===== src/ssr_if.sv =====
// ----------------------------------------------------------------------------
// ssr_req_if / ssr_rsp_if
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface ssr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic       squib_select;
   logic       recorder_select;
   logic [7:0] rx_byte;

   modport source(output valid, func, squib_select, recorder_select, rx_byte,
                  input ready);
   modport sink(input valid, func, squib_select, recorder_select, rx_byte,
                output ready);
endinterface

interface ssr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic [4:0] fire_mask;
   logic       fault_line;
   logic [5:0] status_byte;

   modport source(output valid, tx_byte, fire_mask, fault_line, status_byte,
                  input ready);
   modport sink(input valid, tx_byte, fire_mask, fault_line, status_byte,
                output ready);
endinterface

`default_nettype wire

// ===== src/spi_squib_and_event_register_slave.sv =====
// ----------------------------------------------------------------------------
// spi_squib_and_event_register_slave
// Byte-level SPI slave serving a squib driver and an event recorder.
// ----------------------------------------------------------------------------
// One request beat per clock is sustained while responses are taken, and each
// beat gives exactly one response beat. Each request beat is written into the
// two-entry queue; when the response register is free, the back executor pops
// it and registers the response together with the registered read of the
// register-file memory. The front keeps taking beats while a response waits,
// until the queue is full. The register file comes up in its reset contents
// at once: written entries are tracked by per-entry valid bits, so no clearing
// pass follows reset.
`default_nettype none

module spi_squib_and_event_register_slave #(
   parameter int REG_COUNT = ssr_pkg::REG_COUNT_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   ssr_req_if.sink   req_bus,
   ssr_rsp_if.source rsp_bus
);
   import ssr_pkg::*;

   logic   push;
   logic   pop;
   logic   queue_full;
   logic   head_valid;
   op_type push_op;
   op_type head_op;

   ssr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .queue_full(queue_full),
      .push      (push),
      .push_op   (push_op)
   );

   ssr_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .pop       (pop),
      .full      (queue_full),
      .head_valid(head_valid),
      .head_op   (head_op)
   );

   ssr_back #(
      .REG_COUNT(REG_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_valid(head_valid),
      .head_op   (head_op),
      .pop       (pop),
      .rsp_bus   (rsp_bus)
   );
endmodule

`default_nettype wire

// ===== src/ssr_ram.sv =====
// ----------------------------------------------------------------------------
// ssr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

`default_nettype wire

// ===== src/ssr_front.sv =====
// ----------------------------------------------------------------------------
// ssr_front
// Transaction tracker: latches selects, follows byte index and address, and
// classifies each request beat into a back-end operation.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spi_squib_and_event_register_slave_macros.svh"

module ssr_front (
   input  logic            clock,
   input  logic            reset,
   ssr_req_if.sink         req_bus,
   input  logic            queue_full,
   output logic            push,
   output ssr_pkg::op_type push_op
);
   import ssr_pkg::*;

   typedef enum logic [1:0] {T_NONE, T_SQUIB, T_REC} target_type;

   target_type active_ff, active_in;
   logic [1:0] sel_ff, sel_in;
   logic [7:0] byte_index_ff, byte_index_in;
   logic [6:0] addr_ff, addr_in;
   logic       read_mode_ff, read_mode_in;
   logic       pending_ff, pending_in;
   logic [7:0] held_ff, held_in;
   op_type     op;
   logic       begin_both;

   assign req_bus.ready = !queue_full;
   assign push          = req_bus.valid && !queue_full;
   assign push_op       = op;
   assign begin_both    = push && req_bus.func == FN_BEGIN && req_bus.squib_select &&
                          req_bus.recorder_select;

   always_comb begin
      logic [7:0] b;
      logic       first_cmd;
      b             = req_bus.rx_byte;
      first_cmd     = 1'b0;
      active_in     = active_ff;
      sel_in        = sel_ff;
      byte_index_in = byte_index_ff;
      addr_in       = addr_ff;
      read_mode_in  = read_mode_ff;
      pending_in    = pending_ff;
      held_in       = held_ff;
      op            = '0;
      op.kind       = OP_NOP;
      op.fault_act  = FA_NONE;
      case (req_bus.func)
         FN_BEGIN: begin
            op.kind       = OP_BEGIN;
            sel_in        = {req_bus.recorder_select, req_bus.squib_select};
            active_in     = (sel_in == SEL_BOTH) ? T_NONE : target_type'(sel_in);
            byte_index_in = '0;
            addr_in       = '0;
            read_mode_in  = 1'b0;
            pending_in    = 1'b0;
            held_in       = '0;
         end
         FN_END: begin
            op.kind       = OP_END;
            op.squib      = pending_ff;
            op.data       = held_ff;
            active_in     = T_NONE;
            sel_in        = '0;
            byte_index_in = '0;
            addr_in       = '0;
            read_mode_in  = 1'b0;
            pending_in    = 1'b0;
            held_in       = '0;
         end
         FN_BYTE: begin
            op.kind = OP_BYTE;
            if (byte_index_ff == '0) begin
               if (active_ff == T_REC) begin
                  op.fault_act = FA_CLEAR;
                  first_cmd    = 1'b1;
               end else if (active_ff == T_SQUIB) begin
                  pending_in = 1'b1;
                  held_in    = b;
               end else if (b[7]) begin
                  active_in    = T_REC;
                  op.fault_act = FA_CLEAR;
                  first_cmd    = 1'b1;
               end else begin
                  pending_in = 1'b1;
                  held_in    = b;
                  if (sel_ff == SEL_BOTH) begin
                     op.fault_act = FA_SET_BOTH;
                  end
               end
               if (first_cmd) begin
                  read_mode_in = b[7];
                  addr_in      = b[6:0];
                  op.rd        = b[7];
                  op.read_seen = b[7];
                  op.addr      = b[6:0];
               end
               byte_index_in = byte_index_ff + 8'd1;
            end else begin
               byte_index_in = byte_index_ff + 8'd1;
               if (pending_ff) begin
                  // held first byte becomes the recorder command byte
                  active_in     = T_REC;
                  op.fault_act  = FA_CLEAR;
                  read_mode_in  = held_ff[7];
                  addr_in       = held_ff[6:0];
                  op.read_seen  = held_ff[7];
                  pending_in    = 1'b0;
                  byte_index_in = 8'd2;
               end
               case (active_in)
                  T_SQUIB: begin
                  end
                  T_REC: begin
                     if (read_mode_in) begin
                        addr_in      = addr_in + 7'd1;
                        op.rd        = 1'b1;
                        op.read_seen = 1'b1;
                        op.addr      = addr_in;
                     end else begin
                        op.wr   = 1'b1;
                        op.addr = addr_in;
                        op.data = b;
                        addr_in = addr_in + 7'd1;
                     end
                  end
                  default: begin
                     op.idle_tx = 1'b1;
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= T_NONE;
         sel_ff        <= '0;
         byte_index_ff <= '0;
         addr_ff       <= '0;
         read_mode_ff  <= 1'b0;
         pending_ff    <= 1'b0;
         held_ff       <= '0;
      end else if (push) begin
         active_ff     <= active_in;
         sel_ff        <= sel_in;
         byte_index_ff <= byte_index_in;
         addr_ff       <= addr_in;
         read_mode_ff  <= read_mode_in;
         pending_ff    <= pending_in;
         held_ff       <= held_in;
      end
   end

   `SSR_ASSERT_IMPL(a_held_slot, pending_ff, byte_index_ff == 8'd1, "held byte off slot one")
   `SSR_ASSERT_IMPL(a_held_not_rec, pending_ff, active_ff != T_REC, "held byte on recorder")
   `SSR_ASSERT_NEXT(a_both_sel, begin_both, active_ff == T_NONE, "target with both selects")
endmodule

`default_nettype wire

// ===== src/ssr_fifo.sv =====
// ----------------------------------------------------------------------------
// ssr_fifo
// Short operation queue between the front tracker and the back executor.
// ----------------------------------------------------------------------------
`default_nettype none

module ssr_fifo (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  ssr_pkg::op_type push_op,
   input  logic            pop,
   output logic            full,
   output logic            head_valid,
   output ssr_pkg::op_type head_op
);
   import ssr_pkg::*;

   op_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign full       = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_op    = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_W'(1);
         end
         count_ff <= count_in;
      end
   end
endmodule

`default_nettype wire

// ===== src/ssr_back.sv =====
// ----------------------------------------------------------------------------
// ssr_back
// Operation executor: recorder register file, status, fault and squib drive,
// with a response register toward the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

`include "spi_squib_and_event_register_slave_macros.svh"

module ssr_back #(
   parameter int REG_COUNT = ssr_pkg::REG_COUNT_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            head_valid,
   input  ssr_pkg::op_type head_op,
   output logic            pop,
   ssr_rsp_if.source       rsp_bus
);
   import ssr_pkg::*;

   localparam int IDX_W = $clog2(REG_COUNT);

   logic [5:0]           status_ff, status_in;
   logic [7:0]           fault_reg_ff, fault_reg_in;
   logic [7:0]           log_ff [LOG_N];
   logic [7:0]           log_in [LOG_N];
   logic [15:0]          count_ff, count_in;
   logic [4:0]           mask_ff, mask_in;
   logic                 pin_ff, pin_in;
   logic [REG_COUNT-1:0] valid_ff, valid_in;

   logic       b2_valid_ff;
   logic       b2_sel_ram_ff, b2_sel_ram_in;
   logic [7:0] b2_fixed_ff, b2_fixed_in;
   logic [5:0] b2_status_ff;
   logic [4:0] b2_mask_ff;
   logic       b2_pin_ff;

   logic             out_free;
   logic             ram_we;
   logic [8:0]       addr_ext;
   logic             in_range;
   logic [IDX_W-1:0] idx;
   logic [7:0]       ram_rd_data;

   assign out_free = !b2_valid_ff || rsp_bus.ready;
   assign pop      = head_valid && out_free;
   assign addr_ext = {2'b00, head_op.addr};
   assign in_range = addr_ext < 9'(REG_COUNT);
   assign idx      = addr_ext[IDX_W-1:0];

   always_comb begin
      logic [LOG_IDX_W-1:0] lidx;
      logic                 bad;
      lidx          = LOG_IDX_W'(head_op.addr - A_LOG_FIRST);
      bad           = 1'b0;
      status_in     = status_ff;
      fault_reg_in  = fault_reg_ff;
      log_in        = log_ff;
      count_in      = count_ff;
      mask_in       = mask_ff;
      pin_in        = pin_ff;
      valid_in      = valid_ff;
      ram_we        = 1'b0;
      b2_sel_ram_in = 1'b0;
      b2_fixed_in   = '0;
      if (pop) begin
         case (head_op.kind)
            OP_BEGIN: begin
               count_in = count_ff + 16'd1;
            end
            OP_END: begin
               if (head_op.squib) begin
                  if (head_op.data == CMD_SAFE) begin
                     mask_in = '0;
                  end else if (head_op.data == CMD_FIRE_ODD) begin
                     mask_in = MASK_FIRE_ODD;
                  end else if (head_op.data == CMD_FIRE_EVEN) begin
                     mask_in = MASK_FIRE_EVEN;
                  end else if (head_op.data[7:5] == 3'b000) begin
                     mask_in = head_op.data[4:0];
                  end else begin
                     bad = 1'b1;
                  end
                  pin_in = bad;
                  if (bad) begin
                     fault_reg_in = FAULT_BAD_CMD;
                     status_in    = status_in | ST_FAULT;
                  end else begin
                     fault_reg_in = '0;
                     status_in    = status_in & ~ST_FAULT;
                  end
                  log_in[LOG_LAST_CMD]  = head_op.data;
                  log_in[LOG_SQUIB_OUT] = {3'b000, mask_in};
                  status_in = status_in | ST_SQUIB | ST_LOG;
               end
            end
            OP_BYTE: begin
               case (head_op.fault_act)
                  FA_CLEAR: begin
                     fault_reg_in = '0;
                     status_in    = status_in & ~ST_FAULT;
                  end
                  FA_SET_BOTH: begin
                     fault_reg_in = FAULT_BOTH_SEL;
                     status_in    = status_in | ST_FAULT;
                  end
                  default: begin
                  end
               endcase
               if (head_op.read_seen) begin
                  status_in = status_in | ST_READ;
               end
               if (head_op.rd) begin
                  case (head_op.addr)
                     A_ID:      b2_fixed_in = ID_VALUE;
                     A_STATUS:  b2_fixed_in = {2'b00, status_in};
                     A_COUNT_H: b2_fixed_in = count_ff[15:8];
                     A_COUNT_L: b2_fixed_in = count_ff[7:0];
                     A_CTRL:    b2_fixed_in = '0;
                     A_FAULT:   b2_fixed_in = fault_reg_in;
                     default: begin
                        if (head_op.addr inside {[A_LOG_FIRST:A_LOG_LAST]}) begin
                           b2_fixed_in = log_ff[lidx];
                        end else begin
                           b2_sel_ram_in = in_range && valid_ff[idx];
                        end
                     end
                  endcase
               end
               if (head_op.wr) begin
                  if (head_op.addr inside {A_ID, A_STATUS, A_COUNT_H, A_COUNT_L}) begin
                  end else if (head_op.addr == A_CTRL) begin
                     if (head_op.data[CTRL_RESET_STATUS]) begin
                        status_in    = ST_INIT;
                        fault_reg_in = '0;
                     end
                     if (head_op.data[CTRL_CLEAR_LOG]) begin
                        for (int i = 0; i < LOG_N; i++) begin
                           log_in[i] = '0;
                        end
                     end
                  end else begin
                     if (head_op.addr inside {[A_LOG_FIRST:A_LOG_LAST]}) begin
                        log_in[lidx] = head_op.data;
                     end else if (head_op.addr == A_FAULT) begin
                        fault_reg_in = head_op.data;
                     end else if (in_range) begin
                        ram_we        = 1'b1;
                        valid_in[idx] = 1'b1;
                     end
                     status_in = status_in | ST_WRITE | ST_LOG;
                  end
               end
               if (head_op.idle_tx) begin
                  b2_fixed_in = TX_IDLE;
               end
            end
            default: begin
            end
         endcase
      end
   end

   ssr_ram #(
      .WIDTH(8),
      .DEPTH(REG_COUNT)
   ) u_regfile (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(idx),
      .wr_data(head_op.data),
      .rd_en  (pop),
      .rd_addr(idx),
      .rd_data(ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff    <= ST_INIT;
         fault_reg_ff <= '0;
         log_ff       <= '{default: '0};
         count_ff     <= '0;
         mask_ff      <= '0;
         pin_ff       <= 1'b0;
         valid_ff     <= '0;
         b2_valid_ff  <= 1'b0;
      end else begin
         status_ff    <= status_in;
         fault_reg_ff <= fault_reg_in;
         log_ff       <= log_in;
         count_ff     <= count_in;
         mask_ff      <= mask_in;
         pin_ff       <= pin_in;
         valid_ff     <= valid_in;
         if (out_free) begin
            b2_valid_ff <= pop;
         end
      end
      if (pop) begin
         b2_sel_ram_ff <= b2_sel_ram_in;
         b2_fixed_ff   <= b2_fixed_in;
         b2_status_ff  <= status_in;
         b2_mask_ff    <= mask_in;
         b2_pin_ff     <= pin_in;
      end
   end

   assign rsp_bus.valid       = b2_valid_ff;
   assign rsp_bus.tx_byte     = b2_sel_ram_ff ? ram_rd_data : b2_fixed_ff;
   assign rsp_bus.fire_mask   = b2_mask_ff;
   assign rsp_bus.fault_line  = b2_pin_ff;
   assign rsp_bus.status_byte = b2_status_ff;

   `SSR_ASSERT_IMPL(a_ram_plain, ram_we, !is_special(head_op.addr), "memory write to a flop reg")
   `SSR_ASSERT_IMPL(a_one_access, pop, !(head_op.rd && head_op.wr), "read and write in one beat")
   `SSR_ASSERT_IMPL(a_init_sticky, 1'b1, status_ff[0] == 1'b1, "status init bit lost")
endmodule

`default_nettype wire

// ===== tb/spi_squib_and_event_register_slave_tb.sv =====
// ----------------------------------------------------------------------------
// spi_squib_and_event_register_slave_tb
// Self-checking bench for the squib / event recorder SPI slave. Event beats
// (begin, byte, end, unused code) are sent through the request channel while
// a beat-level predictor of the slave works out each response beat. The
// predictor covers the recorder register file, the sticky status, the control
// register, the squib commands and the fault paths. Responses are checked
// field by field in order. The run uses directed sequences, then recorder,
// squib and noise traffic under three sender and receiver stall mixes.
// ----------------------------------------------------------------------------
module spi_squib_and_event_register_slave_tb;
   import ssr_pkg::*;

   localparam int CYCLE_LIMIT = 300000;

   localparam logic [1:0] TGT_NONE  = 2'd0;
   localparam logic [1:0] TGT_SQUIB = 2'd1;
   localparam logic [1:0] TGT_REC   = 2'd2;

   typedef struct packed {
      logic [7:0] tx_byte;
      logic [4:0] fire_mask;
      logic       fault_line;
      logic [5:0] status_byte;
   } slave_rsp_type;

   logic clock;
   logic reset;

   ssr_req_if req_bus ();
   ssr_rsp_if rsp_bus ();

   spi_squib_and_event_register_slave DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [7:0]  rec_regs [0:127];
   logic [15:0] txn_count;
   logic [1:0]  cur_target;
   logic [1:0]  cur_selects;
   logic [7:0]  rx_index;
   logic [6:0]  rec_addr;
   logic        rec_reading;
   logic        cmd_held;
   logic [7:0]  held_cmd;
   logic [4:0]  squib_drive;
   logic        fault_out;
   logic [7:0]  next_tx;

   slave_rsp_type expected_rsp [$];

   int send_gap_pct;
   int rsp_stall_pct;
   int fail_count;
   int cycle_count;
   int beats_sent;
   int n_begin, n_byte, n_end, n_spare;
   int n_reads, n_writes, n_squib_runs, n_squib_rejects;

   function automatic void flag_fault(input logic [7:0] code);
      rec_regs[A_FAULT] = code;
      rec_regs[A_STATUS] |= 8'(ST_FAULT);
   endfunction

   function automatic void drop_fault();
      rec_regs[A_FAULT] = 8'h00;
      rec_regs[A_STATUS] &= ~8'(ST_FAULT);
   endfunction

   function automatic logic [7:0] recorder_read(input logic [6:0] a);
      n_reads++;
      rec_regs[A_STATUS] |= 8'(ST_READ);
      return rec_regs[a];
   endfunction

   function automatic void recorder_write(input logic [6:0] a, input logic [7:0] v);
      n_writes++;
      if (a == A_ID || a == A_STATUS || a == A_COUNT_H || a == A_COUNT_L)
         return;
      if (a == A_CTRL) begin
         if (v[CTRL_RESET_STATUS]) begin
            rec_regs[A_STATUS] = 8'(ST_INIT);
            drop_fault();
         end
         if (v[CTRL_CLEAR_LOG]) begin
            for (int i = A_LOG_FIRST; i <= A_LOG_LAST; i++)
               rec_regs[i] = 8'h00;
         end
         rec_regs[A_CTRL] = 8'h00;
         return;
      end
      rec_regs[a] = v;
      rec_regs[A_STATUS] |= 8'(ST_WRITE | ST_LOG);
   endfunction

   function automatic void run_squib_cmd(input logic [7:0] cmd);
      logic ok;
      ok = 1'b1;
      n_squib_runs++;
      if (cmd == CMD_SAFE)
         squib_drive = 5'h00;
      else if (cmd == CMD_FIRE_ODD)
         squib_drive = MASK_FIRE_ODD;
      else if (cmd == CMD_FIRE_EVEN)
         squib_drive = MASK_FIRE_EVEN;
      else if (cmd[7:5] == 3'b000)
         squib_drive = cmd[4:0];
      else
         ok = 1'b0;
      if (ok) begin
         fault_out = 1'b0;
         drop_fault();
      end else begin
         n_squib_rejects++;
         fault_out = 1'b1;
         flag_fault(FAULT_BAD_CMD);
      end
      rec_regs[A_LAST_CMD] = cmd;
      rec_regs[A_SQUIB_OUT] = {3'b000, squib_drive};
      rec_regs[A_STATUS] |= 8'(ST_SQUIB | ST_LOG);
   endfunction

   function automatic void recorder_byte(input logic [7:0] b);
      if (rx_index == 8'd0) begin
         rec_reading = b[7];
         rec_addr = b[6:0];
         next_tx = rec_reading ? recorder_read(rec_addr) : 8'h00;
         return;
      end
      if (rec_reading) begin
         rec_addr = rec_addr + 7'd1;
         next_tx = recorder_read(rec_addr);
      end else begin
         recorder_write(rec_addr, b);
         rec_addr = rec_addr + 7'd1;
         next_tx = 8'h00;
      end
   endfunction

   function automatic void hold_cmd(input logic [7:0] b);
      cmd_held = 1'b1;
      held_cmd = b;
      next_tx = 8'h00;
   endfunction

   function automatic void clear_xfer();
      rx_index = 8'd0;
      rec_addr = 7'd0;
      rec_reading = 1'b0;
      cmd_held = 1'b0;
      held_cmd = 8'h00;
   endfunction

   function automatic void slave_power_up();
      for (int i = 0; i < 128; i++)
         rec_regs[i] = 8'h00;
      rec_regs[A_ID] = ID_VALUE;
      rec_regs[A_STATUS] = 8'(ST_INIT);
      txn_count = 16'd0;
      cur_target = TGT_NONE;
      cur_selects = 2'd0;
      clear_xfer();
      squib_drive = 5'h00;
      fault_out = 1'b0;
      next_tx = 8'h00;
   endfunction

   function automatic slave_rsp_type slave_response(input logic [1:0] fn, input logic sq,
                                                    input logic rc, input logic [7:0] b);
      logic          pend;
      logic [7:0]    val;
      slave_rsp_type r;
      next_tx = 8'h00;
      case (fn)
         FN_BEGIN: begin
            n_begin++;
            cur_selects = {rc, sq};
            cur_target = (cur_selects == SEL_BOTH) ? TGT_NONE : cur_selects;
            clear_xfer();
            txn_count = txn_count + 16'd1;
            rec_regs[A_COUNT_H] = txn_count[15:8];
            rec_regs[A_COUNT_L] = txn_count[7:0];
         end
         FN_BYTE: begin
            n_byte++;
            if (rx_index == 8'd0) begin
               if (cur_target == TGT_REC) begin
                  drop_fault();
                  recorder_byte(b);
               end else if (cur_target == TGT_SQUIB) begin
                  hold_cmd(b);
               end else if (b[7]) begin
                  cur_target = TGT_REC;
                  drop_fault();
                  recorder_byte(b);
               end else begin
                  hold_cmd(b);
                  if (cur_selects == SEL_BOTH)
                     flag_fault(FAULT_BOTH_SEL);
               end
            end else begin
               // a held first byte turns into a recorder command
               if (cmd_held) begin
                  cur_target = TGT_REC;
                  rx_index = 8'd0;
                  drop_fault();
                  recorder_byte(held_cmd);
                  rx_index = 8'd1;
                  cmd_held = 1'b0;
               end
               if (cur_target == TGT_SQUIB)
                  next_tx = 8'h00;
               else if (cur_target == TGT_REC)
                  recorder_byte(b);
               else
                  next_tx = TX_IDLE;
            end
            rx_index = rx_index + 8'd1;
         end
         FN_END: begin
            n_end++;
            pend = cmd_held;
            val = held_cmd;
            cur_target = TGT_NONE;
            clear_xfer();
            if (pend)
               run_squib_cmd(val);
            cur_selects = 2'd0;
         end
         default: n_spare++;
      endcase
      r.tx_byte = next_tx;
      r.fire_mask = squib_drive;
      r.fault_line = fault_out;
      r.status_byte = rec_regs[A_STATUS][5:0];
      return r;
   endfunction

   // ---------------------------------------------------------------- sender
   task automatic send_beat(input logic [1:0] fn, input logic sq, input logic rc,
                            input logic [7:0] b);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.func <= fn;
      req_bus.squib_select <= sq;
      req_bus.recorder_select <= rc;
      req_bus.rx_byte <= b;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_begin(input logic sq, input logic rc);
      send_beat(FN_BEGIN, sq, rc, 8'($urandom));
   endtask

   task automatic send_byte(input logic [7:0] b);
      send_beat(FN_BYTE, 1'($urandom), 1'($urandom), b);
   endtask

   task automatic send_end();
      send_beat(FN_END, 1'($urandom), 1'($urandom), 8'($urandom));
   endtask

   // -------------------------------------------------------------- receiver
   always @(negedge clock)
      rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);

   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         expected_rsp.push_back(slave_response(req_bus.func, req_bus.squib_select,
                                               req_bus.recorder_select, req_bus.rx_byte));
   end

   task automatic flag_mismatch(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      if (fail_count < 10)
         $display("mismatch on %s: expected 0x%0h, got 0x%0h", field, want, got);
      fail_count++;
   endtask

   slave_rsp_type want_rsp;

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_rsp.size() == 0) begin
            if (fail_count < 10)
               $display("response beat with nothing expected");
            fail_count++;
         end else begin
            want_rsp = expected_rsp.pop_front();
            if (rsp_bus.tx_byte !== want_rsp.tx_byte)
               flag_mismatch("tx_byte", want_rsp.tx_byte, rsp_bus.tx_byte);
            if (rsp_bus.fire_mask !== want_rsp.fire_mask)
               flag_mismatch("fire_mask", 8'(want_rsp.fire_mask), 8'(rsp_bus.fire_mask));
            if (rsp_bus.fault_line !== want_rsp.fault_line)
               flag_mismatch("fault_line", 8'(want_rsp.fault_line), 8'(rsp_bus.fault_line));
            if (rsp_bus.status_byte !== want_rsp.status_byte)
               flag_mismatch("status_byte", 8'(want_rsp.status_byte),
                             8'(rsp_bus.status_byte));
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d beats outstanding",
                  cycle_count, expected_rsp.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ----------------------------------------------------------------- tests
   task automatic test_directed();
      // byte with no begin is held, a second byte replays it as a recorder write
      send_byte(8'h3C);
      send_byte(8'h55);
      send_end();
      send_beat(FN_SPARE, 1'b1, 1'b1, 8'hFF);
      // id and status readout
      send_begin(1'b0, 1'b1);
      send_byte({1'b1, A_ID});
      send_byte(8'h00);
      send_end();
      // read-only count register ignores the write
      send_begin(1'b0, 1'b1);
      send_byte({1'b0, A_COUNT_H});
      send_byte(8'hFF);
      send_end();
      // squib patterns and a rejected command
      send_begin(1'b1, 1'b0);
      send_byte(CMD_FIRE_ODD);
      send_end();
      send_begin(1'b1, 1'b0);
      send_byte(8'hE7);
      send_end();
      // both selects: fault on the first byte, command still runs at end
      send_begin(1'b1, 1'b1);
      send_byte(8'h12);
      send_end();
      // repeated begin, then control register clears status and log
      send_begin(1'b1, 1'b0);
      send_begin(1'b0, 1'b1);
      send_byte({1'b0, A_CTRL});
      send_byte(8'h03);
      send_end();
      send_begin(1'b1, 1'b0);
      send_byte(CMD_FIRE_EVEN);
      send_end();
   endtask

   task automatic test_recorder_traffic(input int n_txn);
      int         pick;
      int         n_data;
      logic [6:0] a;
      logic       rd;
      logic [7:0] d;
      for (int k = 0; k < n_txn; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 80)
            send_begin(1'b0, 1'b1);
         else if (pick < 90)
            send_begin(1'b0, 1'b0);
         else
            send_begin(1'b1, 1'b1);
         if ($urandom_range(0, 99) < 70)
            a = 7'($urandom_range(A_ID - 3, A_FAULT + 3));
         else
            a = 7'($urandom);
         rd = 1'($urandom);
         send_byte({rd, a});
         n_data = $urandom_range(1, 6);
         for (int j = 0; j < n_data; j++) begin
            d = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom);
            send_byte(d);
         end
         if ($urandom_range(0, 19) != 0)
            send_end();
      end
   endtask

   task automatic test_squib_commands(input int n_txn);
      logic [7:0] cmd;
      for (int k = 0; k < n_txn; k++) begin
         if ($urandom_range(0, 9) == 0)
            send_begin(1'($urandom), 1'($urandom));
         else
            send_begin(1'b1, $urandom_range(0, 9) == 0);
         case ($urandom_range(0, 5))
            0: cmd = CMD_SAFE;
            1: cmd = CMD_FIRE_ODD;
            2: cmd = CMD_FIRE_EVEN;
            3: cmd = {3'b000, 5'($urandom)};
            default: cmd = 8'($urandom);
         endcase
         send_byte(cmd);
         if ($urandom_range(0, 9) == 0)
            send_byte(8'($urandom));
         send_end();
      end
   endtask

   task automatic test_noise(input int n_beats);
      for (int k = 0; k < n_beats; k++)
         send_beat(2'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
   endtask

   // more than 256 bytes in one transaction so the byte index wraps
   task automatic test_long_burst();
      send_begin(1'b0, 1'b1);
      send_byte({1'b1, 7'($urandom)});
      for (int k = 0; k < 259; k++)
         send_byte(8'($urandom));
      send_end();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.func = FN_SPARE;
      req_bus.squib_select = 1'b0;
      req_bus.recorder_select = 1'b0;
      req_bus.rx_byte = 8'h00;
      rsp_bus.ready = 1'b0;
      send_gap_pct = 36;
      rsp_stall_pct = 49;
      slave_power_up();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_directed();
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               send_gap_pct = 36;
               rsp_stall_pct = 49;
            end
            1: begin
               send_gap_pct = 49;
               rsp_stall_pct = 36;
            end
            default: begin
               send_gap_pct = 0;
               rsp_stall_pct = 0;
            end
         endcase
         test_recorder_traffic(25);
         test_squib_commands(25);
         test_noise(30);
         if (ph == 0)
            test_long_burst();
      end
      @(negedge clock);
      req_bus.valid <= 1'b0;

      while (expected_rsp.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("%0d beats: %0d begin, %0d byte, %0d end, %0d unused code",
               beats_sent, n_begin, n_byte, n_end, n_spare);
      $display("recorder %0d reads / %0d writes, squib %0d commands (%0d rejected)",
               n_reads, n_writes, n_squib_runs, n_squib_rejects);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
